>>> hw/rtl/bpkic_pkg.sv
// Shared types and constants for the bounded-probe key-to-id cache.
package bpkic_pkg;

  localparam int SLOTS     = 8192;
  localparam int MAX_PROBE = 16;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int PRB_W = (MAX_PROBE > 1) ? $clog2(MAX_PROBE) : 1;

  localparam int KEY_W = 64;
  localparam int ID_W  = 32;

  // Fibonacci hashing multiplier, split into halves for the 32x32 multiplier.
  localparam logic [63:0] GOLDEN_MUL = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [31:0] GOLDEN_LO  = GOLDEN_MUL[31:0];
  localparam logic [31:0] GOLDEN_HI  = GOLDEN_MUL[63:32];

  typedef enum logic [1:0] {
    STATUS_NULL   = 2'd0,
    STATUS_HIT    = 2'd1,
    STATUS_INSERT = 2'd2,
    STATUS_FULL   = 2'd3
  } status_e;

  // One table slot; a zero key marks the slot as empty.
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
  } slot_t;

  typedef struct packed {
    logic             start;
    logic [KEY_W-1:0] key;
  } hash_req_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] slot;
  } hash_rsp_t;

endpackage

>>> hw/rtl/bpkic_ram.sv
// Generic single-port synchronous RAM with a registered read port.
module bpkic_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/bpkic_hash.sv
// Iterative Fibonacci hash: home slot from one shared 32x32 multiplier.
module bpkic_hash (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bpkic_pkg::hash_req_t  req_i,
  output bpkic_pkg::hash_rsp_t  rsp_o
);

  // Bits [63:32] of (a * C) mod 2^64 are
  //   hi(a_lo*C_lo) + lo(a_hi*C_lo) + lo(a_lo*C_hi); only the low IDX_W bits are kept.
  logic [59:0]                 a_q;
  logic [1:0]                  cnt_q;
  logic                        busy_q;
  logic [63:0]                 prod_q;
  logic [bpkic_pkg::IDX_W-1:0] acc_q;
  logic [31:0]                 op_a;
  logic [31:0]                 op_b;

  always_comb begin
    unique case (cnt_q)
      2'd0: begin
        op_a = a_q[31:0];
        op_b = bpkic_pkg::GOLDEN_LO;
      end
      2'd1: begin
        op_a = {4'b0, a_q[59:32]};
        op_b = bpkic_pkg::GOLDEN_LO;
      end
      2'd2, 2'd3: begin
        op_a = a_q[31:0];
        op_b = bpkic_pkg::GOLDEN_HI;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= 2'd0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 2'd1;
      if (cnt_q == 2'd3) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q <= req_i.key[63:4];
    end
    if (busy_q) begin
      prod_q <= 64'(op_a) * 64'(op_b);
      unique case (cnt_q)
        2'd0: ;
        2'd1: acc_q <= prod_q[32 +: bpkic_pkg::IDX_W];
        2'd2: acc_q <= acc_q + prod_q[bpkic_pkg::IDX_W-1:0];
        2'd3: ;
      endcase
    end
  end

  assign rsp_o.done = busy_q && (cnt_q == 2'd3);
  assign rsp_o.slot = acc_q + prod_q[bpkic_pkg::IDX_W-1:0];

endmodule

>>> hw/rtl/bounded_probe_key_id_cache_top.sv
// Top level of the bounded-probe key-to-id cache: probe sequencer and slot store.
// Path: a zero key goes from acceptance straight to the response state; a nonzero key
//   passes through the hash, probes one to MAX_PROBE slots, then goes through the
//   response state and the output register.
// Handshake: one transaction at a time; the next input is taken the cycle after the
//   result is loaded into the output register, and that load waits on any output stall.
// Reset: asynchronous, active low; afterwards a clearing pass writes every slot
//   empty, one per cycle, with s_axis_tready_o held low.
module bounded_probe_key_id_cache_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [95:0] s_axis_tdata_i,   // [63:0] lookup_key, [95:64] new_id
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] result_id
  output logic [1:0]  m_axis_tuser_o    // [1:0] status
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_RESP
  } state_e;

  state_e                               state_q;
  logic [bpkic_pkg::IDX_W-1:0]          clr_q;
  logic [bpkic_pkg::KEY_W-1:0]          key_q;
  logic [bpkic_pkg::ID_W-1:0]           nid_q;
  logic [bpkic_pkg::IDX_W-1:0]          idx_q;
  logic [bpkic_pkg::PRB_W-1:0]          prb_q;
  logic [bpkic_pkg::ID_W-1:0]           res_id_q;
  bpkic_pkg::status_e                   res_st_q;
  logic                                 m_valid_q;
  logic [bpkic_pkg::ID_W-1:0]           m_data_q;
  bpkic_pkg::status_e                   m_user_q;

  logic                                 in_fire;
  logic                                 out_free;
  logic                                 out_load;
  bpkic_pkg::hash_req_t                 hash_req;
  bpkic_pkg::hash_rsp_t                 hash_rsp;

  logic                                 ram_en;
  logic                                 ram_we;
  logic [bpkic_pkg::IDX_W-1:0]          ram_addr;
  bpkic_pkg::slot_t                     ram_wdata;
  bpkic_pkg::slot_t                     ram_rdata;

  logic                                 slot_hit;
  logic                                 slot_empty;
  logic                                 last_probe;
  logic [bpkic_pkg::IDX_W-1:0]          idx_next;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign out_load        = (state_q == S_RESP) && out_free;

  // Start the hash only for a real key; a zero key bypasses the table.
  assign hash_req.start = in_fire && (s_axis_tdata_i[63:0] != '0);
  assign hash_req.key   = s_axis_tdata_i[63:0];

  bpkic_hash u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (hash_req),
    .rsp_o  (hash_rsp)
  );

  // Compare the slot read in the previous cycle against the held key.
  assign slot_hit   = (ram_rdata.key == key_q);
  assign slot_empty = (ram_rdata.key == '0);
  assign last_probe = (prb_q == bpkic_pkg::PRB_W'(bpkic_pkg::MAX_PROBE - 1));
  assign idx_next   = idx_q + 1'b1;  // wraps modulo SLOTS by width

  // Single memory port: clear sweep, first probe read, follow-on reads, insert write.
  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = idx_q;
    ram_wdata = '{id: nid_q, key: key_q};
    unique case (state_q)
      S_CLEAR: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
      end
      S_HASH: begin
        ram_en   = hash_rsp.done;
        ram_addr = hash_rsp.slot;
      end
      S_PROBE: begin
        priority if (slot_hit) begin
          ram_en = 1'b0;
        end else if (slot_empty) begin
          // Claim the empty slot; the next item cannot read it before this lands.
          ram_en = 1'b1;
          ram_we = 1'b1;
        end else if (!last_probe) begin
          ram_en   = 1'b1;
          ram_addr = idx_next;
        end
      end
      S_IDLE, S_RESP: ;
      default: ;
    endcase
  end

  bpkic_ram #(
    .WIDTH ($bits(bpkic_pkg::slot_t)),
    .DEPTH (bpkic_pkg::SLOTS)
  ) u_slots (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      key_q     <= '0;
      nid_q     <= '0;
      idx_q     <= '0;
      prb_q     <= '0;
      res_id_q  <= '0;
      res_st_q  <= bpkic_pkg::STATUS_NULL;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_user_q  <= bpkic_pkg::STATUS_NULL;
    end else begin
      // Load a finished result when the output register is free; otherwise drop
      // the output transaction once the sink takes it.
      if (out_load) begin
        m_valid_q <= 1'b1;
        m_data_q  <= res_id_q;
        m_user_q  <= res_st_q;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == bpkic_pkg::IDX_W'(bpkic_pkg::SLOTS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            key_q <= s_axis_tdata_i[63:0];
            nid_q <= s_axis_tdata_i[95:64];
            if (s_axis_tdata_i[63:0] == '0) begin
              res_id_q <= '0;
              res_st_q <= bpkic_pkg::STATUS_NULL;
              state_q  <= S_RESP;
            end else begin
              state_q <= S_HASH;
            end
          end
        end
        S_HASH: begin
          if (hash_rsp.done) begin
            idx_q   <= hash_rsp.slot;
            prb_q   <= '0;
            state_q <= S_PROBE;
          end
        end
        S_PROBE: begin
          priority if (slot_hit) begin
            res_id_q <= ram_rdata.id;
            res_st_q <= bpkic_pkg::STATUS_HIT;
            state_q  <= S_RESP;
          end else if (slot_empty) begin
            res_id_q <= nid_q;
            res_st_q <= bpkic_pkg::STATUS_INSERT;
            state_q  <= S_RESP;
          end else if (last_probe) begin
            res_id_q <= nid_q;
            res_st_q <= bpkic_pkg::STATUS_FULL;
            state_q  <= S_RESP;
          end else begin
            idx_q <= idx_next;
            prb_q <= prb_q + 1'b1;
          end
        end
        S_RESP: begin
          // Hold the result until the output register is free.
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

endmodule

>>> hw/rtl/bpkic_checker.sv
// Port-level checker for the key-to-id cache, bound to the top level.
module bpkic_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [95:0] s_axis_tdata_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("output changed while stalled");

  // A null-key result always carries id zero.
  a_null_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == bpkic_pkg::STATUS_NULL) |->
      (m_axis_tdata_o == '0))
    else $error("null status with nonzero id");

  // One item at a time: after a transaction the input side is busy.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken on consecutive cycles");

  // A nonzero key is not turned round as fast as a null key: the hash keeps the input busy.
  a_hash_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && (s_axis_tdata_i[63:0] != '0) |=>
      ##1 !s_axis_tready_o)
    else $error("lookup finished faster than the hash");

endmodule

bind bounded_probe_key_id_cache_top bpkic_checker u_bpkic_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

>>> tb/bounded_probe_key_id_cache_top_test.sv
// Self-checking stream testbench for the bounded-probe key-to-id cache top level.
module bounded_probe_key_id_cache_top_test;

  localparam int NUM_RANDOM  = 2000;
  // Slowest run: the clear sweep, then per item the longest idle gap, the lookup itself
  // and the longest output stall; the limit allows several times that.
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOT_HOMES   = 16;
  localparam int DRAIN_WAIT  = 40;

  // One result transaction: id on tdata, status on tuser.
  typedef struct packed {
    logic [bpkic_pkg::ID_W-1:0] id;
    bpkic_pkg::status_e         status;
  } lookup_res_t;

  // One directed stimulus row; typed rows carry their expectation literally.
  typedef struct {
    logic [bpkic_pkg::KEY_W-1:0] key;
    logic [bpkic_pkg::ID_W-1:0]  id;
    bit                          typed;
    lookup_res_t                 res;
  } lookup_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [95:0] s_axis_tdata_i;   // [63:0] lookup_key, [95:64] new_id
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [31:0] m_axis_tdata_o;   // [31:0] result_id
  logic [1:0]  m_axis_tuser_o;   // [1:0] status

  // Shadow copy of the slot store, kept in step with accepted lookups.
  logic [bpkic_pkg::KEY_W-1:0] shadow_key [bpkic_pkg::SLOTS];
  logic [bpkic_pkg::ID_W-1:0]  shadow_id  [bpkic_pkg::SLOTS];

  lookup_res_t                 pending_results[$];
  lookup_row_t                 directed_rows[$];
  logic [bpkic_pkg::KEY_W-1:0] used_keys[$];
  logic [bpkic_pkg::IDX_W-1:0] hot_home [HOT_HOMES];
  logic [bpkic_pkg::KEY_W-1:0] golden_inv;
  int                          mismatches = 0;
  int                          cycles = 0;
  int                          send_burst = 0;
  int                          recv_burst = 0;

  bounded_probe_key_id_cache_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Fibonacci hash: bits [32 +: IDX_W] of (key >> 4) * golden, i.e. the upper
  // half masked to the slot count.
  function automatic logic [bpkic_pkg::IDX_W-1:0] home_of(
      logic [bpkic_pkg::KEY_W-1:0] key);
    logic [63:0] prod;
    prod = (key >> 4) * bpkic_pkg::GOLDEN_MUL;
    return prod[32 +: bpkic_pkg::IDX_W];
  endfunction

  // Walk the probe window, update the shadow store on an insert, return the result.
  function automatic lookup_res_t predict_lookup(logic [bpkic_pkg::KEY_W-1:0] key,
                                                 logic [bpkic_pkg::ID_W-1:0] nid);
    logic [bpkic_pkg::IDX_W-1:0] idx;
    if (key == '0) return '{'0, bpkic_pkg::STATUS_NULL};
    idx = home_of(key);
    for (int n = 0; n < bpkic_pkg::MAX_PROBE; n++) begin
      if (shadow_key[idx] == key) return '{shadow_id[idx], bpkic_pkg::STATUS_HIT};
      if (shadow_key[idx] == '0) begin
        shadow_key[idx] = key;
        shadow_id[idx]  = nid;
        return '{nid, bpkic_pkg::STATUS_INSERT};
      end
      idx = idx + 1'b1;  // wraps at the top of the table
    end
    return '{nid, bpkic_pkg::STATUS_FULL};
  endfunction

  // Build a random nonzero key whose home slot is h: fix the hash bits of a
  // random product, divide by the odd multiplier, and keep quotients that fit
  // in 60 bits so the shift by 4 can be undone.
  function automatic logic [bpkic_pkg::KEY_W-1:0] key_at_home(
      logic [bpkic_pkg::IDX_W-1:0] h);
    logic [63:0] prod;
    logic [63:0] quot;
    do begin
      prod = {$urandom(), $urandom()};
      prod[32 +: bpkic_pkg::IDX_W] = h;
      quot = prod * golden_inv;
    end while (quot[63:60] != 4'd0 || quot == '0);
    return {quot[59:0], 4'($urandom())};
  endfunction

  // Idle cycles before the next transaction; bursts of back-to-back ones between.
  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) burst = $urandom_range(8, 40);
    return $urandom_range(0, 19);
  endfunction

  function automatic void add_row(logic [bpkic_pkg::KEY_W-1:0] key,
                                  logic [bpkic_pkg::ID_W-1:0] id, bit typed,
                                  lookup_res_t res);
    lookup_row_t row;
    row = '{key, id, typed, res};
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  // Offer one lookup, hold it until accepted, then record what must come back.
  task automatic send_lookup(input logic [bpkic_pkg::KEY_W-1:0] key,
                             input logic [bpkic_pkg::ID_W-1:0] nid,
                             input bit typed, input lookup_res_t typed_res);
    int          gap;
    lookup_res_t pred;
    gap = draw_gap(send_burst);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {nid, key};
    do @(posedge clk_i); while (!s_axis_tready_o);
    // Run the predictor even for typed rows so the shadow store stays in step.
    pred = predict_lookup(key, nid);
    pending_results.insert(pending_results.size(), typed ? typed_res : pred);
    if (key != '0) used_keys.insert(used_keys.size(), key);
  endtask

  // Stimulus and end of run.
  initial begin
    logic [bpkic_pkg::KEY_W-1:0] key;
    logic [bpkic_pkg::ID_W-1:0]  nid;
    int                          pick;

    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    m_axis_tready_i <= 1'b0;

    for (int s = 0; s < bpkic_pkg::SLOTS; s++) begin
      shadow_key[s] = '0;
      shadow_id[s]  = '0;
    end

    // Inverse of the odd multiplier modulo 2^64 by Newton iteration.
    golden_inv = bpkic_pkg::GOLDEN_MUL;
    repeat (6) golden_inv = golden_inv * (64'd2 - bpkic_pkg::GOLDEN_MUL * golden_inv);

    // Crowd a few neighborhoods, two of them across the wrap at the table end.
    hot_home[0] = bpkic_pkg::IDX_W'(bpkic_pkg::SLOTS - 1);
    hot_home[1] = bpkic_pkg::IDX_W'(bpkic_pkg::SLOTS - 6);
    hot_home[2] = bpkic_pkg::IDX_W'(3);
    hot_home[3] = bpkic_pkg::IDX_W'(bpkic_pkg::SLOTS / 4);
    hot_home[4] = bpkic_pkg::IDX_W'(bpkic_pkg::SLOTS / 4 + 6);
    for (int i = 5; i < HOT_HOMES; i++) hot_home[i] = bpkic_pkg::IDX_W'($urandom());

    // Null key: id 0, nothing stored, new_id ignored.
    add_row(64'd0, 32'hFFFF_FFFF, 1'b1, '{32'd0, bpkic_pkg::STATUS_NULL});
    add_row(64'd0, 32'd0, 1'b1, '{32'd0, bpkic_pkg::STATUS_NULL});
    // Largest key into an empty table, then found again.
    add_row({bpkic_pkg::KEY_W{1'b1}}, 32'hFFFF_FFFF, 1'b1,
            '{32'hFFFF_FFFF, bpkic_pkg::STATUS_INSERT});
    add_row({bpkic_pkg::KEY_W{1'b1}}, 32'd0, 1'b1,
            '{32'hFFFF_FFFF, bpkic_pkg::STATUS_HIT});
    // Keys 1..15 all hash to slot 0 and fill slots 0..14.
    for (int k = 1; k < 16; k++) begin
      add_row(bpkic_pkg::KEY_W'(k), 32'(k) * 32'h1111_1111, 1'b0, '0);
    end
    // Multiples of 2^49 also hash to slot 0: the first takes slot 15, the next
    // finds the window full.
    add_row(64'h0002_0000_0000_0000, 32'h8000_0001, 1'b0, '0);
    add_row(64'h0004_0000_0000_0000, 32'hA5A5_5A5A, 1'b1,
            '{32'hA5A5_5A5A, bpkic_pkg::STATUS_FULL});
    add_row(64'h0000_0000_0000_000F, 32'd0, 1'b0, '0);
    add_row(64'h8000_0000_0000_0000, 32'd1, 1'b0, '0);
    // Last slot: one insert there, then a second key wraps into the full window.
    add_row(key_at_home(bpkic_pkg::IDX_W'(bpkic_pkg::SLOTS - 1)), 32'h0F0F_F0F0, 1'b0, '0);
    add_row(key_at_home(bpkic_pkg::IDX_W'(bpkic_pkg::SLOTS - 1)), 32'h7FFF_FFFF, 1'b0, '0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      send_lookup(directed_rows[i].key, directed_rows[i].id, directed_rows[i].typed,
                  directed_rows[i].res);
    end

    // Random part: mostly keys aimed at crowded neighborhoods and repeats of
    // earlier keys, with fully random keys and null keys mixed in.
    for (int i = 0; i < NUM_RANDOM; i++) begin
      pick = $urandom_range(0, 99);
      nid  = $urandom();
      if (pick < 8) begin
        key = '0;
      end else if (pick < 30 && used_keys.size() > 0) begin
        key = used_keys[$urandom_range(0, used_keys.size() - 1)];
      end else if (pick < 45) begin
        key = {$urandom(), $urandom()};
      end else begin
        key = key_at_home(hot_home[$urandom_range(0, HOT_HOMES - 1)]);
      end
      send_lookup(key, nid, 1'b0, '0);
    end
    s_axis_tvalid_i <= 1'b0;

    // Drain outstanding results, then give the block time to show any extra one.
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Result side: stall at random, then take one transaction and check it.
  initial begin
    int          stall;
    lookup_res_t want;
    wait (rst_ni === 1'b1);
    forever begin
      stall = draw_gap(recv_burst);
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      if (pending_results.size() == 0) begin
        $error("unexpected result: result_id %h status %0d", m_axis_tdata_o, m_axis_tuser_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata_o !== want.id) begin
          $error("result_id mismatch: expected %h, got %h", want.id, m_axis_tdata_o);
          mismatches++;
        end
        if (m_axis_tuser_o !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, m_axis_tuser_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk_i) begin
    cycles = cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

endmodule
